### rtl/core/mkh_pkg.sv
// ============================================================================
// mkh_pkg
// Shared constants and types for the MurmurHash2 key hash unit.
// ============================================================================
package mkh_pkg;

    localparam logic [31:0] MIX_M     = 32'h5bd1e995;
    localparam int unsigned MIX_R     = 24;
    localparam int unsigned FIN_R1    = 13;
    localparam int unsigned FIN_R2    = 15;
    localparam logic [31:0] HASH_MASK = 32'hEFFFFFFF;

    // finished hash offered by the sequencer to the output stage
    typedef struct packed {
        logic        valid;
        logic [31:0] data;
    } res_t;

endpackage

### rtl/core/mkh_mul.sv
// ============================================================================
// mkh_mul
// Shared multiplier: registered low 32 bits of operand times the mix constant.
// ============================================================================
module mkh_mul (
    input  logic        aclk,
    input  logic [31:0] operand,
    output logic [31:0] product
);

    logic [31:0] product_reg;
    logic [31:0] product_next;

    assign product_next = operand * mkh_pkg::MIX_M;

    always_ff @(posedge aclk) begin
        product_reg <= product_next;
    end

    assign product = product_reg;

endmodule

### rtl/core/mkh_ctrl.sv
// ============================================================================
// mkh_ctrl
// Sequencer and hash datapath; a multiplier step a cycle, waits in IDLE/DONE.
// ============================================================================
module mkh_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_accept,
    input  logic [31:0]       in_word,
    input  logic [7:0]        in_length,
    input  logic              in_last,
    output logic              idle,
    output mkh_pkg::res_t     res,
    input  logic              res_ack,
    output logic [31:0]       mul_operand,
    input  logic [31:0]       mul_product
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MULW,
        S_MULH,
        S_MULK,
        S_MIX,
        S_MULT,
        S_TAILW,
        S_FIN0,
        S_FIN1,
        S_DONE
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] hash_reg, hash_next;
    logic [31:0] word_reg, word_next;
    logic [31:0] k_reg, k_next;
    logic [31:0] result_reg, result_next;
    logic [7:0]  length_reg, length_next;
    logic        busy_reg, busy_next;
    logic        last_reg, last_next;

    logic [7:0]  len_eff;
    logic [31:0] hash_start;
    logic [31:0] tail_mask;
    logic [31:0] k_shift;
    logic [31:0] fin_shift;
    logic [31:0] fin_out;

    // length is taken only on the first word of a key
    assign len_eff    = busy_reg ? length_reg : in_length;
    assign hash_start = busy_reg ? hash_reg : {24'd0, in_length};

    always_comb begin
        case (len_eff[1:0])
            2'd1:    tail_mask = 32'h000000FF;
            2'd2:    tail_mask = 32'h0000FFFF;
            2'd3:    tail_mask = 32'h00FFFFFF;
            default: tail_mask = 32'hFFFFFFFF;
        endcase
    end

    assign k_shift   = k_reg ^ (k_reg >> mkh_pkg::MIX_R);
    assign fin_shift = hash_reg ^ (hash_reg >> mkh_pkg::FIN_R1);
    assign fin_out   = (mul_product ^ (mul_product >> mkh_pkg::FIN_R2)) & mkh_pkg::HASH_MASK;

    always_comb begin
        case (state_reg)
            S_MULW:  mul_operand = word_reg;
            S_MULH:  mul_operand = hash_reg;
            S_MULK:  mul_operand = k_shift;
            S_MULT:  mul_operand = hash_reg;
            S_FIN0:  mul_operand = fin_shift;
            default: mul_operand = word_reg;
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        hash_next   = hash_reg;
        word_next   = word_reg;
        k_next      = k_reg;
        result_next = result_reg;
        length_next = length_reg;
        busy_next   = busy_reg;
        last_next   = last_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    word_next   = in_word;
                    last_next   = in_last;
                    length_next = len_eff;
                    if (!busy_reg && in_length == 8'd0) begin
                        // zero-length key: word passes through untouched
                        result_next = in_word;
                        hash_next   = '0;
                        state_next  = S_DONE;
                    end else if (in_last && len_eff[1:0] != 2'd0) begin
                        busy_next  = 1'b1;
                        hash_next  = hash_start ^ (in_word & tail_mask);
                        state_next = S_MULT;
                    end else begin
                        busy_next  = 1'b1;
                        hash_next  = hash_start;
                        state_next = S_MULW;
                    end
                end
            end
            S_MULW: state_next = S_MULH;
            S_MULH: begin
                k_next     = mul_product;
                state_next = S_MULK;
            end
            S_MULK: begin
                hash_next  = mul_product;
                state_next = S_MIX;
            end
            S_MIX: begin
                hash_next  = hash_reg ^ mul_product;
                state_next = last_reg ? S_FIN0 : S_IDLE;
            end
            S_MULT: state_next = S_TAILW;
            S_TAILW: begin
                hash_next  = mul_product;
                state_next = S_FIN0;
            end
            S_FIN0: state_next = S_FIN1;
            S_FIN1: begin
                result_next = fin_out;
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (res_ack) begin
                    hash_next  = '0;
                    busy_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            hash_reg   <= '0;
            busy_reg   <= 1'b0;
            length_reg <= '0;
        end else begin
            state_reg  <= state_next;
            hash_reg   <= hash_next;
            busy_reg   <= busy_next;
            length_reg <= length_next;
        end
        word_reg   <= word_next;
        k_reg      <= k_next;
        result_reg <= result_next;
        last_reg   <= last_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res.valid = (state_reg == S_DONE);
    assign res.data  = result_reg;

`ifndef NO_ASSERTIONS
    a_zero_len_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && idle && !busy_reg && in_length == 8'd0)
        |=> (state_reg == S_DONE && result_reg == $past(in_word)))
        else $error("zero-length key did not pass its word through");

    a_mid_word_keeps_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MIX && !last_reg) |=> (state_reg == S_IDLE && busy_reg))
        else $error("unmarked word ended the key");

    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && res_ack) |=> (!busy_reg && hash_reg == 32'd0))
        else $error("running hash not cleared after result");

    a_busy_not_idle_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MULW || state_reg == S_MULT) |-> busy_reg)
        else $error("mixing step without a key in progress");
`endif

endmodule

### rtl/core/murmur2_key_hash_unit.sv
// ============================================================================
// murmur2_key_hash_unit
// Streaming MurmurHash2 (seed zero, bit 28 of the hash cleared) of a key given as 32-bit words.
// ============================================================================
// Steps: unmarked word MULW, MULH, MULK, MIX; last full word adds FIN0, FIN1;
//   last tail word MULT, TAILW, FIN0, FIN1; zero-length key straight to DONE.
// Throughput: one item at a time; the single registered 32x32 multiplier is
//   used three times per full word and once more for the final avalanche.
// Reset: synchronous, active low; clears the sequencer, running hash and output valid flag.
module murmur2_key_hash_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_key_word,
    input  logic [7:0]  s_key_length,
    input  logic        s_last_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash_value
);

    mkh_pkg::res_t res;
    logic          res_ack;
    logic          idle;
    logic [31:0]   mul_operand;
    logic [31:0]   mul_product;
    logic          out_valid_reg, out_valid_next;
    logic [31:0]   out_data_reg, out_data_next;

    mkh_mul u_mul (
        .aclk    (aclk),
        .operand (mul_operand),
        .product (mul_product)
    );

    mkh_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (s_valid && s_ready),
        .in_word     (s_key_word),
        .in_length   (s_key_length),
        .in_last     (s_last_word),
        .idle        (idle),
        .res         (res),
        .res_ack     (res_ack),
        .mul_operand (mul_operand),
        .mul_product (mul_product)
    );

    assign s_ready = idle;

    // output register takes a result when empty or draining this cycle
    assign res_ack = res.valid && (!out_valid_reg || m_ready);

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (res_ack) begin
            out_valid_next = 1'b1;
            out_data_next  = res.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_hash_value = out_data_reg;

endmodule

### verif/mkh_hash_checker.sv
// ============================================================================
// mkh_hash_checker
// Watches both channels of the key hash unit, predicts each finished hash
// from the accepted key words and compares it with the accepted result.
// ============================================================================
module mkh_hash_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_key_word,
    input  logic [7:0]  s_key_length,
    input  logic        s_last_word,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_hash_value,
    output int          fail_count,
    output int          pending_hashes
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    logic [31:0] key_hash;
    logic        key_open;
    logic [7:0]  key_len;
    logic [31:0] expected_hashes[$];
    int          mismatches;

    function automatic logic [31:0] mix_word(input logic [31:0] h, input logic [31:0] w);
        logic [31:0] k;
        logic [31:0] hm;
        k  = w * mkh_pkg::MIX_M;
        k  = k ^ (k >> mkh_pkg::MIX_R);
        k  = k * mkh_pkg::MIX_M;
        hm = h * mkh_pkg::MIX_M;
        return hm ^ k;
    endfunction

    function automatic logic [31:0] avalanche(input logic [31:0] h);
        logic [31:0] a;
        a = h ^ (h >> mkh_pkg::FIN_R1);
        a = a * mkh_pkg::MIX_M;
        a = a ^ (a >> mkh_pkg::FIN_R2);
        return a & mkh_pkg::HASH_MASK;
    endfunction

    initial begin
        fail_count     = 0;
        pending_hashes = 0;
        mismatches     = 0;
        key_hash       = '0;
        key_open       = 1'b0;
        key_len        = '0;
    end

    always @(posedge aclk) begin
        logic [31:0] h;
        logic [31:0] tail_mask;
        logic [31:0] want;
        if (!aresetn) begin
            key_hash = '0;
            key_open = 1'b0;
            key_len  = '0;
            expected_hashes.delete();
        end else begin
            // compare first so a result never matches a hash queued this edge
            if (m_valid && m_ready) begin
                if (expected_hashes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected hash %08h, none pending", $time, m_hash_value);
                end else begin
                    want = expected_hashes.pop_front();
                    if (m_hash_value !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: hash_value expected %08h, got %08h",
                                     $time, want, m_hash_value);
                    end
                end
            end

            if (s_valid && s_ready) begin
                if (!key_open) begin
                    key_len = s_key_length;
                    if (s_key_length == 8'd0) begin
                        // empty key passes its word straight through
                        expected_hashes.push_back(s_key_word);
                    end else begin
                        key_hash = {24'd0, s_key_length};
                        key_open = 1'b1;
                    end
                end
                if (key_open) begin
                    h = key_hash;
                    if (!s_last_word) begin
                        key_hash = mix_word(h, s_key_word);
                    end else begin
                        case (key_len[1:0])
                            2'd1:    tail_mask = 32'h0000_00FF;
                            2'd2:    tail_mask = 32'h0000_FFFF;
                            2'd3:    tail_mask = 32'h00FF_FFFF;
                            default: tail_mask = 32'hFFFF_FFFF;
                        endcase
                        if (key_len[1:0] == 2'd0) begin
                            h = mix_word(h, s_key_word);
                        end else begin
                            h = h ^ (s_key_word & tail_mask);
                            h = h * mkh_pkg::MIX_M;
                        end
                        expected_hashes.push_back(avalanche(h));
                        key_hash = '0;
                        key_open = 1'b0;
                    end
                end
            end
        end
        fail_count     <= mismatches;
        pending_hashes <= expected_hashes.size();
    end

endmodule

### verif/tb_top.sv
// ============================================================================
// tb_top
// Key hash unit regression: directed keys covering empty keys, every tail
// size, mismatched word markers and the length extremes, then random keys
// with bursty input and a stalling result side. Checking lives in the checker.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 800;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 24;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PATTERN
    } ready_mode_e;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [31:0] s_key_word   = '0;
    logic [7:0]  s_key_length = '0;
    logic        s_last_word  = 1'b0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [31:0] m_hash_value;

    int          fail_count;
    int          pending_hashes;
    int          cycle_count  = 0;
    int          items_sent   = 0;
    int          burst_left   = 0;

    ready_mode_e ready_mode   = READY_ALWAYS;
    int          mode_left    = 0;
    logic [7:0]  ready_bits   = 8'hFF;

    murmur2_key_hash_unit u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_key_word   (s_key_word),
        .s_key_length (s_key_length),
        .s_last_word  (s_last_word),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

    mkh_hash_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_key_word     (s_key_word),
        .s_key_length   (s_key_length),
        .s_last_word    (s_last_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hash_value   (m_hash_value),
        .fail_count     (fail_count),
        .pending_hashes (pending_hashes)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: switches between stall styles, drawing a new style and hold time as each runs out
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            ready_mode <= ready_mode_e'($urandom_range(3));
            mode_left  <= $urandom_range(300, 50);
            ready_bits <= 8'($urandom_range(255, 1));
        end else begin
            mode_left  <= mode_left - 1;
            ready_bits <= {ready_bits[0], ready_bits[7:1]};
        end
        case (ready_mode)
            READY_ALWAYS: m_ready <= 1'b1;
            READY_COIN:   m_ready <= 1'($urandom_range(1));
            READY_SPARSE: m_ready <= ($urandom_range(3) == 0);
            default:      m_ready <= ready_bits[0];
        endcase
    end

    task automatic send_item(input logic [31:0] word, input logic [7:0] len,
                             input logic last);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20)
                                                  : $urandom_range(8, 1);
            s_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge aclk);
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_key_word   <= word;
        s_key_length <= len;
        s_last_word  <= last;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_random_key();
        int unsigned sel;
        int unsigned len;
        int unsigned nwords;
        sel = $urandom_range(99);
        if (sel < 12)      len = 0;
        else if (sel < 70) len = $urandom_range(16, 1);
        else if (sel < 92) len = $urandom_range(64, 17);
        else               len = $urandom_range(255, 65);
        nwords = (len == 0) ? 1 : (len + 3) / 4;
        // occasionally the last marker lands early or late
        if ($urandom_range(9) == 0)
            nwords = $urandom_range(nwords + 2, 1);
        for (int unsigned i = 0; i < nwords; i++) begin
            send_item($urandom(),
                      (i == 0) ? 8'(len) : 8'($urandom()),
                      (len == 0 && nwords == 1) ? 1'($urandom_range(1))
                                                : (i == nwords - 1));
        end
    endtask

    initial begin
        int start_count;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty keys, marked and unmarked
        send_item(32'hFFFF_FFFF, 8'd0, 1'b1);
        send_item(32'h0000_0000, 8'd0, 1'b0);
        // single-word keys: each tail size and a full word
        send_item(32'hFFFF_FFFF, 8'd1, 1'b1);
        send_item(32'hA5A5_A5A5, 8'd2, 1'b1);
        send_item(32'h0000_0000, 8'd3, 1'b1);
        send_item(32'hFFFF_FFFF, 8'd4, 1'b1);
        // two-word keys; length on the second word is ignored
        send_item(32'h1234_5678, 8'd5, 1'b0);
        send_item(32'hFFFF_FF9A, 8'hFF, 1'b1);
        send_item(32'hDEAD_BEEF, 8'd8, 1'b0);
        send_item(32'h8000_0001, 8'd0, 1'b1);
        // marker earlier than the length says
        send_item(32'hFFFF_FFFF, 8'd255, 1'b0);
        send_item(32'h0102_0304, 8'd255, 1'b1);
        send_item(32'h7FFF_FFFF, 8'd128, 1'b1);
        // marker later than the length says
        send_item(32'h0000_0001, 8'd4, 1'b0);
        send_item(32'hCAFE_F00D, 8'd4, 1'b0);
        send_item(32'h5555_AAAA, 8'd4, 1'b1);
        send_item(32'hFFFF_FFFF, 8'd6, 1'b0);
        send_item(32'h0000_0000, 8'd6, 1'b0);
        send_item(32'hFFFF_FFFF, 8'd6, 1'b1);

        start_count = items_sent;
        while (items_sent < start_count + RANDOM_ITEMS)
            send_random_key();
        s_valid <= 1'b0;

        do @(posedge aclk); while (pending_hashes != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
